[design/edfs_pkg.sv]
package edfs_pkg;

  localparam int NUM_TASKS  = 8;
  localparam int TIME_WIDTH = 16;
  localparam int STEP_W     = 32;
  localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W      = 6;
  localparam int MASK_W     = (NUM_TASKS < 8) ? NUM_TASKS : 8;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [2:0]  task_index;
    logic [15:0] start_time;
    logic [15:0] rel_deadline;
    logic [15:0] period;
    logic [15:0] exec_time;
  } in_t;

  typedef struct packed {
    logic [31:0] step_number;
    logic        run_valid;
    logic [2:0]  run_task;
    logic [31:0] run_deadline;
    logic [7:0]  missed_mask;
    logic [7:0]  released_mask;
  } res_t;

  typedef struct packed {
    logic             load;
    logic             init;
    logic             div_step;
    logic             update;
    logic             select;
    logic             dec;
    logic [IDX_W-1:0] dec_idx;
  } cell_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [STEP_W:0]  dl;
  } cand_t;

endpackage

[design/edfs_cell.sv]
module edfs_cell import edfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  in_t               load_i,
  input  logic [STEP_W-1:0] step_i,
  input  cand_t             cand_i,
  output cand_t             cand_o,
  output logic              miss_o,
  output logic              rel_o
);

  logic [TIME_WIDTH-1:0] start_q, dlen_q, per_q, exec_q, remw_q;
  logic [STEP_W-1:0]     d_q;
  logic                  act_q;
  logic [TIME_WIDTH-1:0] rd_q, rp_q;
  logic                  own_v_q;
  logic [STEP_W:0]       own_dl_q;
  cand_t                 cand_q;
  logic                  miss_q, rel_q;

  logic [TIME_WIDTH-1:0] len, plen, rd_d, rp_d, rem_rel;
  logic [TIME_WIDTH:0]   tmp_d, tmp_p, sum;
  logic                  rel_now;

  always_comb begin
    len     = (dlen_q == '0) ? TIME_WIDTH'(1) : dlen_q;
    plen    = (per_q == '0) ? TIME_WIDTH'(1) : per_q;
    tmp_d   = {rd_q, d_q[STEP_W-1]};
    tmp_p   = {rp_q, d_q[STEP_W-1]};
    rd_d    = (tmp_d >= {1'b0, len}) ? TIME_WIDTH'(tmp_d - {1'b0, len}) : TIME_WIDTH'(tmp_d);
    rp_d    = (tmp_p >= {1'b0, plen}) ? TIME_WIDTH'(tmp_p - {1'b0, plen}) : TIME_WIDTH'(tmp_p);
    sum     = {1'b0, remw_q} + {1'b0, exec_q};
    rel_now = act_q && (rp_q == '0);
    rem_rel = remw_q;
    if (rel_now) begin
      rem_rel = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      dlen_q   <= TIME_WIDTH'(1);
      per_q    <= TIME_WIDTH'(1);
      exec_q   <= '0;
      remw_q   <= '0;
      d_q      <= '0;
      act_q    <= 1'b0;
      rd_q     <= '0;
      rp_q     <= '0;
      own_v_q  <= 1'b0;
      own_dl_q <= '0;
      cand_q   <= '0;
      miss_q   <= 1'b0;
      rel_q    <= 1'b0;
    end else begin
      if (ctrl_i.load && (32'(load_i.task_index) == 32'(idx_i))) begin
        start_q <= TIME_WIDTH'(load_i.start_time);
        dlen_q  <= TIME_WIDTH'(load_i.rel_deadline);
        per_q   <= TIME_WIDTH'(load_i.period);
        exec_q  <= TIME_WIDTH'(load_i.exec_time);
        remw_q  <= '0;
      end
      if (ctrl_i.init) begin
        d_q    <= step_i - STEP_W'(start_q);
        act_q  <= step_i >= STEP_W'(start_q);
        rd_q   <= '0;
        rp_q   <= '0;
        miss_q <= 1'b0;
        rel_q  <= 1'b0;
      end
      if (ctrl_i.div_step) begin
        rd_q <= rd_d;
        rp_q <= rp_d;
        d_q  <= {d_q[STEP_W-2:0], 1'b0};
      end
      if (ctrl_i.update) begin
        miss_q   <= act_q && (rd_q == '0) && (remw_q != '0);
        rel_q    <= rel_now;
        remw_q   <= rem_rel;
        own_v_q  <= act_q && (rem_rel != '0);
        own_dl_q <= {1'b0, step_i} + (STEP_W+1)'(len - TIME_WIDTH'(1) - rd_q);
      end
      if (ctrl_i.select) begin
        if (own_v_q && (!cand_i.valid || (own_dl_q < cand_i.dl))) begin
          cand_q <= '{valid: 1'b1, idx: idx_i, dl: own_dl_q};
        end else begin
          cand_q <= cand_i;
        end
      end
      if (ctrl_i.dec && (ctrl_i.dec_idx == idx_i)) begin
        remw_q <= remw_q - TIME_WIDTH'(1);
      end
    end
  end

  assign cand_o = cand_q;
  assign miss_o = miss_q;
  assign rel_o  = rel_q;

endmodule

[design/edf_periodic_task_scheduler_core.sv]
// EDF scheduler over NUM_TASKS periodic tasks held in a chain of cells, one
// task per cell. A load beat writes its cell without raising busy. In a tick
// beat each cell first runs a bit-serial remainder of its 32-bit phase by
// deadline and period, then the earliest-deadline candidate ripples down
// the chain one cell per cycle. busy is high throughout a tick; the result
// appears with res_valid_o for a single cycle and must be captured then,
// the receiver cannot stall it.
module edf_periodic_task_scheduler_core import edfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  in_i,
  output logic busy,
  output res_t res_o,
  output logic res_valid_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SEL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              accept;
  cell_ctrl_t        ctrl;
  cand_t             chain [NUM_TASKS+1];
  logic [NUM_TASKS-1:0] miss_v, rel_v;
  cand_t             best;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign chain[0] = '0;
  assign best   = chain[NUM_TASKS];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    ctrl    = '0;
    ctrl.dec_idx = best.idx;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.action == ACT_LOAD)) begin
          ctrl.load = 1'b1;
        end
        if (accept && (in_i.action == ACT_TICK)) begin
          if (step_q != '1) begin
            step_d = step_q + STEP_W'(1);
          end
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        ctrl.init = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(STEP_W)) begin
          ctrl.update = 1'b1;
          cnt_d       = '0;
          state_d     = ST_SEL;
        end else begin
          ctrl.div_step = 1'b1;
          cnt_d         = cnt_q + CNT_W'(1);
        end
      end
      ST_SEL: begin
        ctrl.select = 1'b1;
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_TASKS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        ctrl.dec = best.valid;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    edfs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .ctrl_i (ctrl),
      .load_i (in_i),
      .step_i (step_q),
      .cand_i (chain[g]),
      .cand_o (chain[g+1]),
      .miss_o (miss_v[g]),
      .rel_o  (rel_v[g])
    );
  end

  always_comb begin
    res_o               = '0;
    res_o.step_number   = step_q;
    res_o.missed_mask   = 8'(miss_v[MASK_W-1:0]);
    res_o.released_mask = 8'(rel_v[MASK_W-1:0]);
    if (best.valid) begin
      res_o.run_valid    = 1'b1;
      res_o.run_task     = 3'(best.idx);
      res_o.run_deadline = best.dl[STEP_W] ? '1 : best.dl[STEP_W-1:0];
    end
  end

  assign res_valid_o = (state_q == ST_DONE);

`ifndef SYNTH
  a_res_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe longer than one cycle");
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.action == ACT_TICK) |=> busy) else $error("tick did not start");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.action == ACT_LOAD) |=> !busy) else $error("load made block busy");
  a_norun_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.run_valid) |-> (res_o.run_task == 3'd0 && res_o.run_deadline == '0))
    else $error("idle result carries task data");
`endif

endmodule

[test/edfs_checker.sv]
module edfs_checker import edfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  in_t  in_i,
  input  res_t res_i,
  input  logic res_valid_i,
  output int   errors_o,
  output int   pending_o
);

  logic [63:0] step_cnt;
  logic [15:0] t_start [NUM_TASKS];
  logic [15:0] t_dl    [NUM_TASKS];
  logic [15:0] t_per   [NUM_TASKS];
  logic [15:0] t_exec  [NUM_TASKS];
  logic [15:0] t_rem   [NUM_TASKS];

  res_t sched_q[$];

  assign pending_o = sched_q.size();

  function automatic logic [63:0] nz(logic [15:0] v);
    return (v == 16'd0) ? 64'd1 : {48'd0, v};
  endfunction

  // one tick: misses, releases, then earliest-deadline pick
  task automatic schedule_tick();
    res_t        r;
    logic [63:0] d, len, n, k, dl, best_dl, sum;
    logic        found;
    int          best;
    found   = 1'b0;
    best    = 0;
    best_dl = '0;
    r       = '0;
    if (step_cnt < 64'hFFFF_FFFF) step_cnt = step_cnt + 1;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (step_cnt >= {48'd0, t_start[i]}) begin
        d = step_cnt - t_start[i];
        if (d % nz(t_dl[i]) == 0 && t_rem[i] != 0) r.missed_mask[i] = 1'b1;
        if (d % nz(t_per[i]) == 0) begin
          sum = {48'd0, t_rem[i]} + {48'd0, t_exec[i]};
          t_rem[i] = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
          r.released_mask[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (step_cnt >= {48'd0, t_start[i]} && t_rem[i] != 0) begin
        len = nz(t_dl[i]);
        n   = step_cnt - t_start[i] + 1;
        k   = (n + len - 1) / len;
        dl  = k * len + t_start[i] - 1;
        if (!found || dl < best_dl) begin
          found   = 1'b1;
          best    = i;
          best_dl = dl;
        end
      end
    end
    if (found) t_rem[best] = t_rem[best] - 1;
    r.step_number  = step_cnt[31:0];
    r.run_valid    = found;
    r.run_task     = found ? best[2:0] : 3'd0;
    r.run_deadline = !found ? 32'd0 : (best_dl > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                : best_dl[31:0];
    sched_q = {sched_q, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      errors_o <= 0;
      step_cnt = '0;
      sched_q.delete();
      for (int i = 0; i < NUM_TASKS; i++) begin
        t_start[i] = '0;
        t_dl[i]    = 16'd1;
        t_per[i]   = 16'd1;
        t_exec[i]  = '0;
        t_rem[i]   = '0;
      end
    end else begin
      if (res_valid_i) begin
        if (sched_q.size() == 0) begin
          $error("result beat with nothing expected: step %0d", res_i.step_number);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = sched_q.pop_front();
          if (res_i !== exp_r) begin
            errors_o <= errors_o + 1;
            if (res_i.step_number !== exp_r.step_number)
              $error("step_number exp %0d got %0d", exp_r.step_number, res_i.step_number);
            if (res_i.run_valid !== exp_r.run_valid)
              $error("run_valid exp %0d got %0d", exp_r.run_valid, res_i.run_valid);
            if (res_i.run_task !== exp_r.run_task)
              $error("run_task exp %0d got %0d", exp_r.run_task, res_i.run_task);
            if (res_i.run_deadline !== exp_r.run_deadline)
              $error("run_deadline exp %0d got %0d", exp_r.run_deadline,
                     res_i.run_deadline);
            if (res_i.missed_mask !== exp_r.missed_mask)
              $error("missed_mask exp %h got %h", exp_r.missed_mask, res_i.missed_mask);
            if (res_i.released_mask !== exp_r.released_mask)
              $error("released_mask exp %h got %h", exp_r.released_mask,
                     res_i.released_mask);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (in_i.action == ACT_LOAD) begin
          if (in_i.task_index < NUM_TASKS) begin
            t_start[in_i.task_index] = in_i.start_time;
            t_dl[in_i.task_index]    = in_i.rel_deadline;
            t_per[in_i.task_index]   = in_i.period;
            t_exec[in_i.task_index]  = in_i.exec_time;
            t_rem[in_i.task_index]   = '0;
          end
        end else begin
          schedule_tick();
        end
      end
    end
  end

endmodule

[test/edf_periodic_task_scheduler_core_tb.sv]
module edf_periodic_task_scheduler_core_tb;
  import edfs_pkg::*;

  localparam int WD_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  in_t  in_i = '0;
  logic busy;
  res_t res_o;
  logic res_valid_o;
  int   errors;
  int   pending;
  int   idle_cnt = 0;
  int   ticks = 0;
  bit   gaps_on = 1'b1;

  always #1 clk_i = ~clk_i;

  edf_periodic_task_scheduler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .in_i(in_i),
    .busy(busy), .res_o(res_o), .res_valid_o(res_valid_o)
  );

  edfs_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .in_i(in_i),
    .res_i(res_o), .res_valid_i(res_valid_o), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(in_t item);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= item;
    if (item.action == ACT_TICK) ticks++;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic in_t mk_load(int idx, int st, int dl, int per, int ex);
    in_t it;
    it.action       = ACT_LOAD;
    it.task_index   = idx[2:0];
    it.start_time   = st[15:0];
    it.rel_deadline = dl[15:0];
    it.period       = per[15:0];
    it.exec_time    = ex[15:0];
    return it;
  endfunction

  function automatic in_t mk_tick();
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom});
    it.action = ACT_TICK;
    return it;
  endfunction

  function automatic in_t mk_random(int now);
    in_t it;
    int  sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return mk_tick();
    if (sel < 90)
      return mk_load($urandom_range(0, 7), now + $urandom_range(0, 20),
                     $urandom_range(0, 12), $urandom_range(0, 16),
                     $urandom_range(0, 6));
    it = in_t'({$urandom, $urandom, $urandom});
    it.action = ACT_LOAD;
    return it;
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(mk_load(0, 0, 3, 4, 2));
    send(mk_load(1, 5, 0, 0, 1));
    send(mk_load(2, 65535, 65535, 65535, 65535));
    send(mk_load(3, 2, 2, 1, 65535));
    repeat (8) send(mk_tick());
    send(mk_load(7, 0, 1, 2, 0));
    send(mk_load(3, 0, 1, 1, 0));
    send(mk_load(4, 10, 5, 3, 1));
    send(mk_load(5, 10, 5, 3, 1));
    repeat (6) send(mk_tick());

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    for (int i = 0; i < 650; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send(mk_random(ticks));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
